/* hw/rtl/foc_inverse_park_clarke_svm_defines.svh */
// assertion macros shared by the voltage stage rtl
`ifndef FOC_INVERSE_PARK_CLARKE_SVM_DEFINES_SVH
`define FOC_INVERSE_PARK_CLARKE_SVM_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define FOCSVM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define FOCSVM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/focsvm_pkg.sv */
// constants, types and helper functions of the foc voltage stage
`default_nettype none

package focsvm_pkg;

	// table size, amplitude and torque range are powers of two
	localparam int TableSize      = 1024;
	localparam int TableAmplitude = 1024;
	localparam int PoleCount      = 14;
	localparam int PwmTop         = 1024;
	localparam int TorqueMax      = 1024;

	localparam int TorqueW = 11;
	localparam int PhaseW  = 11;
	localparam int AngleW  = 12;
	localparam int DutyW   = 10;

	localparam int TableW   = $clog2(TableSize);
	localparam int AmpShift = $clog2(TableAmplitude);
	localparam int SineW    = AmpShift + 2;
	localparam int TmShift  = $clog2(TorqueMax);

	// electrical angle is angle * poles / 8
	localparam int ElecShift = 3;
	localparam int PoleW     = $clog2(PoleCount + 1);
	localparam int ThetaW    = AngleW + PoleW;

	// sqrt3 / 2 as 1773 / 2048, centring gain 591 / 1024
	localparam int Sqrt3Num    = 1773;
	localparam int Sqrt3Shift  = 11;
	localparam int Sqrt3W      = 12;
	localparam int CentreNum   = 591;
	localparam int CentreShift = 10;
	localparam int CentreW     = 11;

	localparam int QdW      = TorqueW + 1;
	localparam int ProdQW   = QdW + SineW;
	localparam int RotW     = ProdQW + 1;
	localparam int AbW      = QdW + 1;
	localparam int BkProdW  = AbW + Sqrt3W;
	localparam int PhW      = AbW + 1;
	localparam int DiffW    = PhW + 1;
	localparam int CenProdW = DiffW + CentreW;
	localparam int PosW     = CenProdW - CentreShift + 1;
	localparam int PwmW     = $clog2(PwmTop) + 1;
	localparam int ScaleW   = PosW + PwmW;
	localparam int WideW    = 64;

	localparam longint unsigned PiQ30 = 64'd3373259426;

	// ceil(2^42 / (2i(2i+1))) for the ten series terms, exact for dividends below 2^32
	localparam int              TaylorShift = 42;
	localparam longint unsigned TaylorOne   = 64'd1 << TaylorShift;
	localparam longint unsigned TaylorRecip [10] = '{
		(TaylorOne + 64'd5) / 64'd6,
		(TaylorOne + 64'd19) / 64'd20,
		(TaylorOne + 64'd41) / 64'd42,
		(TaylorOne + 64'd71) / 64'd72,
		(TaylorOne + 64'd109) / 64'd110,
		(TaylorOne + 64'd155) / 64'd156,
		(TaylorOne + 64'd209) / 64'd210,
		(TaylorOne + 64'd271) / 64'd272,
		(TaylorOne + 64'd341) / 64'd342,
		(TaylorOne + 64'd419) / 64'd420
	};

	typedef logic signed [SineW-1:0] sine_t;
	typedef sine_t sine_rom_t [TableSize];

	typedef struct packed {
		logic signed [AbW-1:0] alpha;
		logic signed [AbW-1:0] beta;
		logic                  sel;
	} ab_t;

	typedef struct packed {
		logic [DutyW-1:0] ch1;
		logic [DutyW-1:0] ch2;
		logic [DutyW-1:0] ch3;
		logic             motor;
	} duty_t;

	// quadrant-reduced taylor series in q30, halves rounded up in magnitude
	function automatic sine_t sine_entry(int unsigned k);
		longint unsigned n;
		longint unsigned t;
		longint unsigned tr;
		longint unsigned x;
		longint unsigned term;
		longint unsigned acc;
		longint unsigned v;
		logic [127:0]    wide;
		logic            neg;
		int              i;
		n   = 64'(TableSize);
		t   = 64'(k) * 64'd4;
		neg = 1'b0;
		if (t <= n) begin
			tr = t;
		end else if (t <= 64'd2 * n) begin
			tr = 64'd2 * n - t;
		end else if (t <= 64'd3 * n) begin
			tr  = t - 64'd2 * n;
			neg = 1'b1;
		end else begin
			tr  = 64'd4 * n - t;
			neg = 1'b1;
		end
		// twice the table size is a power of two
		x    = (PiQ30 * tr) >> (TableW + 1);
		term = x;
		acc  = x;
		for (i = 1; i <= 10; i++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			wide = 128'(term) * 128'(TaylorRecip[i-1]);
			term = 64'(wide >> TaylorShift);
			if (i[0])
				acc = acc - term;
			else
				acc = acc + term;
		end
		v = (acc * 64'(TableAmplitude) + (64'd1 << 29)) >> 30;
		return neg ? -SineW'(v) : SineW'(v);
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t r;
		int        i;
		for (i = 0; i < TableSize; i++)
			r[i] = sine_entry(i);
		return r;
	endfunction

	// signed divide by a power of two, truncating toward zero
	function automatic logic signed [WideW-1:0] sdiv_pow2(logic signed [WideW-1:0] x,
			int unsigned sh);
		logic signed [WideW-1:0] bias;
		bias = x[WideW-1] ? ((WideW'(1) << sh) - WideW'(1)) : '0;
		return (x + bias) >>> sh;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/focsvm_if.sv */
// item and duty channel interfaces of the foc voltage stage
`default_nettype none

interface focsvm_item_if;
	import focsvm_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [TorqueW-1:0]       torque_mag;
	logic signed [PhaseW-1:0] field_phase;
	logic [AngleW-1:0]        enc_angle;
	logic                     motor_sel;

	modport source (output valid, output torque_mag, output field_phase,
		output enc_angle, output motor_sel, input ready);
	modport sink (input valid, input torque_mag, input field_phase,
		input enc_angle, input motor_sel, output ready);
endinterface

interface focsvm_duty_if;
	import focsvm_pkg::*;
	logic             valid;
	logic             ready;
	logic [DutyW-1:0] duty_ch1;
	logic [DutyW-1:0] duty_ch2;
	logic [DutyW-1:0] duty_ch3;
	logic             motor_out;

	modport source (output valid, output duty_ch1, output duty_ch2,
		output duty_ch3, output motor_out, input ready);
	modport sink (input valid, input duty_ch1, input duty_ch2,
		input duty_ch3, input motor_out, output ready);
endinterface

`default_nettype wire

/* hw/rtl/focsvm_sine_rom.sv */
// dual-read sine rom with registered read data
`default_nettype none

module focsvm_sine_rom (
	input  logic                          clk,
	input  logic                          en,
	input  logic [focsvm_pkg::TableW-1:0] addr_a,
	input  logic [focsvm_pkg::TableW-1:0] addr_b,
	output focsvm_pkg::sine_t             data_a,
	output focsvm_pkg::sine_t             data_b
);
	import focsvm_pkg::*;

	localparam sine_rom_t Rom = build_sine_rom();

	sine_t rd_a_q;
	sine_t rd_b_q;

	always_ff @(posedge clk) begin
		if (en) begin
			rd_a_q <= Rom[addr_a];
			rd_b_q <= Rom[addr_b];
		end
	end

	assign data_a = rd_a_q;
	assign data_b = rd_b_q;

endmodule

`default_nettype wire

/* hw/rtl/focsvm_rotate.sv */
// table lookups, field rotation and inverse park, stages s1 to s4
`default_nettype none
`include "foc_inverse_park_clarke_svm_defines.svh"

module focsvm_rotate (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [focsvm_pkg::TorqueW-1:0]      torque_mag,
	input  logic signed [focsvm_pkg::PhaseW-1:0] field_phase,
	input  logic [focsvm_pkg::AngleW-1:0]       enc_angle,
	input  logic                                motor_sel,
	output logic                                out_valid,
	input  logic                                out_ready,
	output focsvm_pkg::ab_t                     ab
);
	import focsvm_pkg::*;

	logic adv1, adv2, adv3, adv4;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	logic [TableW-1:0] ph_idx, ph_cos_idx, th_idx, th_cos_idx;
	logic [ThetaW-1:0] theta_full;

	sine_t              sin_ph_s1, cos_ph_s1, sin_th_s1, cos_th_s1;
	logic [TorqueW-1:0] torque_s1;
	logic               sel_s1;

	logic signed [ProdQW-1:0] prod_q, prod_d;
	logic signed [QdW-1:0]    q_s2, d_s2;
	sine_t                    sin_th_s2, cos_th_s2;
	logic                     sel_s2;

	logic signed [ProdQW-1:0] p_dc_s3, p_qs_s3, p_ds_s3, p_qc_s3;
	logic                     sel_s3;

	logic signed [RotW-1:0] alpha_sum, beta_sum;
	logic signed [AbW-1:0]  alpha_s4, beta_s4;
	logic                   sel_s4;

	// a stage loads when empty or when the next one moves on
	assign adv4     = !vld_s4 || out_ready;
	assign adv3     = !vld_s3 || adv4;
	assign adv2     = !vld_s2 || adv3;
	assign adv1     = !vld_s1 || adv2;
	assign in_ready = adv1;

	// negative phases wrap by two's complement truncation
	assign ph_idx     = TableW'(field_phase);
	assign ph_cos_idx = ph_idx + TableW'(TableSize / 4);
	assign theta_full = ThetaW'(enc_angle) * ThetaW'(PoleCount);
	assign th_idx     = TableW'(theta_full >> ElecShift);
	assign th_cos_idx = th_idx + TableW'(TableSize / 4);

	focsvm_sine_rom u_rom_ph (
		.clk    (clk),
		.en     (adv1),
		.addr_a (ph_idx),
		.addr_b (ph_cos_idx),
		.data_a (sin_ph_s1),
		.data_b (cos_ph_s1)
	);

	focsvm_sine_rom u_rom_th (
		.clk    (clk),
		.en     (adv1),
		.addr_a (th_idx),
		.addr_b (th_cos_idx),
		.data_a (sin_th_s1),
		.data_b (cos_th_s1)
	);

	assign prod_q = $signed({1'b0, torque_s1}) * cos_ph_s1;
	assign prod_d = $signed({1'b0, torque_s1}) * sin_ph_s1;

	assign alpha_sum = RotW'(p_dc_s3) - RotW'(p_qs_s3);
	assign beta_sum  = RotW'(p_ds_s3) + RotW'(p_qc_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= in_valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			torque_s1 <= torque_mag;
			sel_s1    <= motor_sel;
		end
		if (adv2) begin
			q_s2      <= QdW'(sdiv_pow2(WideW'(prod_q), AmpShift));
			d_s2      <= QdW'(sdiv_pow2(WideW'(prod_d), AmpShift));
			sin_th_s2 <= sin_th_s1;
			cos_th_s2 <= cos_th_s1;
			sel_s2    <= sel_s1;
		end
		if (adv3) begin
			p_dc_s3 <= d_s2 * cos_th_s2;
			p_qs_s3 <= q_s2 * sin_th_s2;
			p_ds_s3 <= d_s2 * sin_th_s2;
			p_qc_s3 <= q_s2 * cos_th_s2;
			sel_s3  <= sel_s2;
		end
		if (adv4) begin
			alpha_s4 <= AbW'(sdiv_pow2(WideW'(alpha_sum), AmpShift));
			beta_s4  <= AbW'(sdiv_pow2(WideW'(beta_sum), AmpShift));
			sel_s4   <= sel_s3;
		end
	end

	assign out_valid = vld_s4;
	assign ab        = '{alpha: alpha_s4, beta: beta_s4, sel: sel_s4};

	`FOCSVM_ASSERT_NEXT(a_rot_hold, vld_s4 && !out_ready,
		vld_s4 && $stable(alpha_s4) && $stable(beta_s4), "stalled rotation beat changed")

endmodule

`default_nettype wire

/* hw/rtl/focsvm_centre.sv */
// inverse clarke, min/max centring and duty scaling, stages s5 to s9
`default_nettype none
`include "foc_inverse_park_clarke_svm_defines.svh"

module focsvm_centre (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  focsvm_pkg::ab_t   ab,
	output logic              out_valid,
	input  logic              out_ready,
	output focsvm_pkg::duty_t duty
);
	import focsvm_pkg::*;

	logic adv5, adv6, adv7, adv8, adv9;
	logic vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	logic signed [AbW-1:0]     alpha_s5, half_s5;
	logic signed [BkProdW-1:0] bprod_s5;
	logic                      sel_s5;

	logic signed [PhW-1:0] bk, neg_half;
	logic signed [PhW-1:0] a_s6, b_s6, c_s6;
	logic                  sel_s6;

	logic signed [PhW-1:0]   mn, mx;
	logic signed [DiffW-1:0] mid_sum;
	logic signed [PhW-1:0]   a_s7, b_s7, c_s7, mid_s7;
	logic                    sel_s7;

	logic signed [DiffW-1:0]    diff_a, diff_b, diff_c;
	logic signed [CenProdW-1:0] cen_a_s8, cen_b_s8, cen_c_s8;
	logic                       sel_s8;

	logic [DutyW-1:0] duty_a, duty_b, duty_c;
	duty_t            duty_s9;

	logic signed [PhW+1:0] abc_sum;

	function automatic logic [DutyW-1:0] duty_of(logic signed [CenProdW-1:0] cen);
		logic signed [PosW-1:0]   pos;
		logic signed [ScaleW-1:0] scaled;
		pos    = PosW'(sdiv_pow2(WideW'(cen), CentreShift)) + PosW'(TorqueMax / 2);
		scaled = ScaleW'(sdiv_pow2(WideW'(pos) * WideW'(PwmTop), TmShift));
		if (scaled < 0)
			scaled = '0;
		else if (scaled > ScaleW'(PwmTop - 1))
			scaled = ScaleW'(PwmTop - 1);
		return DutyW'(scaled);
	endfunction

	assign adv9     = !vld_s9 || out_ready;
	assign adv8     = !vld_s8 || adv9;
	assign adv7     = !vld_s7 || adv8;
	assign adv6     = !vld_s6 || adv7;
	assign adv5     = !vld_s5 || adv6;
	assign in_ready = adv5;

	assign bk       = PhW'(sdiv_pow2(WideW'(bprod_s5), Sqrt3Shift));
	assign neg_half = -PhW'(half_s5);

	always_comb begin
		mn = (a_s6 < b_s6) ? a_s6 : b_s6;
		mn = (mn < c_s6) ? mn : c_s6;
		mx = (a_s6 > b_s6) ? a_s6 : b_s6;
		mx = (mx > c_s6) ? mx : c_s6;
	end
	assign mid_sum = DiffW'(mn) + DiffW'(mx);

	assign diff_a = DiffW'(a_s7) - DiffW'(mid_s7);
	assign diff_b = DiffW'(b_s7) - DiffW'(mid_s7);
	assign diff_c = DiffW'(c_s7) - DiffW'(mid_s7);

	assign duty_a = duty_of(cen_a_s8);
	assign duty_b = duty_of(cen_b_s8);
	assign duty_c = duty_of(cen_c_s8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (adv5) vld_s5 <= in_valid;
			if (adv6) vld_s6 <= vld_s5;
			if (adv7) vld_s7 <= vld_s6;
			if (adv8) vld_s8 <= vld_s7;
			if (adv9) vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv5) begin
			alpha_s5 <= ab.alpha;
			half_s5  <= AbW'(sdiv_pow2(WideW'(ab.alpha), 1));
			bprod_s5 <= ab.beta * BkProdW'(Sqrt3Num);
			sel_s5   <= ab.sel;
		end
		if (adv6) begin
			a_s6   <= PhW'(alpha_s5);
			b_s6   <= neg_half + bk;
			c_s6   <= neg_half - bk;
			sel_s6 <= sel_s5;
		end
		if (adv7) begin
			mid_s7 <= PhW'(sdiv_pow2(WideW'(mid_sum), 1));
			a_s7   <= a_s6;
			b_s7   <= b_s6;
			c_s7   <= c_s6;
			sel_s7 <= sel_s6;
		end
		if (adv8) begin
			cen_a_s8 <= diff_a * CenProdW'(CentreNum);
			cen_b_s8 <= diff_b * CenProdW'(CentreNum);
			cen_c_s8 <= diff_c * CenProdW'(CentreNum);
			sel_s8   <= sel_s7;
		end
		if (adv9) begin
			// left motor has phases a and b swapped on the first two channels
			duty_s9.ch1   <= sel_s8 ? duty_a : duty_b;
			duty_s9.ch2   <= sel_s8 ? duty_b : duty_a;
			duty_s9.ch3   <= duty_c;
			duty_s9.motor <= sel_s8;
		end
	end

	assign out_valid = vld_s9;
	assign duty      = duty_s9;

	// b + c is minus twice the truncated half, so the phases sum to alpha's lost bit
	assign abc_sum = (PhW+2)'(a_s6) + (PhW+2)'(b_s6) + (PhW+2)'(c_s6);

	`FOCSVM_ASSERT_NOW(a_phase_sum, vld_s6,
		(abc_sum == 0) || (abc_sum == 1) || (abc_sum == -1), "phase sum off balance")
	`FOCSVM_ASSERT_NOW(a_mid_range, vld_s7,
		((mid_s7 >= a_s7) || (mid_s7 >= b_s7) || (mid_s7 >= c_s7)) &&
		((mid_s7 <= a_s7) || (mid_s7 <= b_s7) || (mid_s7 <= c_s7)),
		"midpoint outside phase range")

endmodule

`default_nettype wire

/* hw/rtl/foc_inverse_park_clarke_svm.sv */
// Field-oriented voltage stage: each beat on item carries a torque magnitude,
// a field phase index, an encoder angle and a motor select, and yields one
// beat on result with three centred PWM duties (space-vector style) and the
// echoed motor select. The datapath is a nine-stage pipeline that takes one
// beat per clock while result is not stalled; an accepted item passes through
// stages s1 to s9 in order and waits in s9 until result is ready. One item
// per cycle is possible because the four sine reads per item are served by
// two dual-read copies of the sine rom in the first stage. Each stage has its
// own valid bit and loads whenever it is empty or its successor moves, so
// bubbles close up and a stall on result holds every beat in place without
// loss. There are no configuration registers.
`default_nettype none

module foc_inverse_park_clarke_svm (
	input  logic          clk,
	input  logic          arst_n,
	focsvm_item_if.sink   item,
	focsvm_duty_if.source result
);
	import focsvm_pkg::*;

	logic  ab_valid;
	logic  ab_ready;
	ab_t   ab;
	duty_t duty;

	focsvm_rotate u_rotate (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (item.valid),
		.in_ready    (item.ready),
		.torque_mag  (item.torque_mag),
		.field_phase (item.field_phase),
		.enc_angle   (item.enc_angle),
		.motor_sel   (item.motor_sel),
		.out_valid   (ab_valid),
		.out_ready   (ab_ready),
		.ab          (ab)
	);

	focsvm_centre u_centre (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ab_valid),
		.in_ready  (ab_ready),
		.ab        (ab),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.duty      (duty)
	);

	assign result.duty_ch1  = duty.ch1;
	assign result.duty_ch2  = duty.ch2;
	assign result.duty_ch3  = duty.ch3;
	assign result.motor_out = duty.motor;

endmodule

`default_nettype wire
